// ----- hdl/macd_pkg.sv -----
// Package: microcode control word, field codes and the sequencer program ROM.
`timescale 1ns / 1ps
`default_nettype none
package macd_pkg;

   localparam int CSR_DATA_BITS  = 17;
   localparam int CSR_INDEX_BITS = 2;
   localparam int PC_BITS        = 5;

   typedef logic [PC_BITS-1:0] pc_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ALPHA_SHORT  = 2'd0,
      CSR_ALPHA_LONG   = 2'd1,
      CSR_ALPHA_SIGNAL = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      D_NONE,
      D_SHORT,
      D_LONG,
      D_SIGNAL
   } d_src_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_LO,
      MUL_HI
   } mul_op_type;

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [2:0] {
      WB_NONE,
      WB_SHORT,
      WB_LONG,
      WB_DIFF,
      WB_SIGNAL,
      WB_SEED
   } wb_op_type;

   typedef enum logic [1:0] {
      ALPHA_SHORT,
      ALPHA_LONG,
      ALPHA_SIGNAL
   } alpha_sel_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_SEED,
      JMP_ALWAYS
   } jmp_type;

   typedef struct packed {
      logic          wait_in;
      logic          emit;
      d_src_type     d_src;
      mul_op_type    mul_op;
      acc_op_type    acc_op;
      wb_op_type     wb_op;
      alpha_sel_type alpha_sel;
      jmp_type       jmp;
      pc_type        target;
   } ctl_word_type;

   localparam pc_type PC_WAIT = 5'd0;
   localparam pc_type PC_EMIT = 5'd16;
   localparam pc_type PC_SEED = 5'd17;

   localparam ctl_word_type CTL_NOP = '{
      wait_in: 1'b0, emit: 1'b0, d_src: D_NONE, mul_op: MUL_NONE, acc_op: ACC_NONE,
      wb_op: WB_NONE, alpha_sel: ALPHA_SHORT, jmp: JMP_NEXT, target: PC_WAIT
   };

   // each average: load delta, low partial, high partial, accumulate, write back
   function automatic ctl_word_type ucode(input pc_type pc);
      ctl_word_type w;
      begin
         w = CTL_NOP;
         case (pc)
            5'd0: begin
               w.wait_in = 1'b1;
            end
            5'd1: begin
               w.d_src  = D_SHORT;
               w.jmp    = JMP_SEED;
               w.target = PC_SEED;
            end
            5'd2: begin
               w.mul_op = MUL_LO;
               w.alpha_sel = ALPHA_SHORT;
            end
            5'd3: begin
               w.mul_op = MUL_HI;
               w.alpha_sel = ALPHA_SHORT;
               w.acc_op = ACC_LOAD;
            end
            5'd4: begin
               w.acc_op = ACC_ADD;
            end
            5'd5: begin
               w.wb_op = WB_SHORT;
               w.d_src = D_LONG;
            end
            5'd6: begin
               w.mul_op = MUL_LO;
               w.alpha_sel = ALPHA_LONG;
            end
            5'd7: begin
               w.mul_op = MUL_HI;
               w.alpha_sel = ALPHA_LONG;
               w.acc_op = ACC_LOAD;
            end
            5'd8: begin
               w.acc_op = ACC_ADD;
            end
            5'd9: begin
               w.wb_op = WB_LONG;
            end
            5'd10: begin
               w.wb_op = WB_DIFF;
            end
            5'd11: begin
               w.d_src = D_SIGNAL;
            end
            5'd12: begin
               w.mul_op = MUL_LO;
               w.alpha_sel = ALPHA_SIGNAL;
            end
            5'd13: begin
               w.mul_op = MUL_HI;
               w.alpha_sel = ALPHA_SIGNAL;
               w.acc_op = ACC_LOAD;
            end
            5'd14: begin
               w.acc_op = ACC_ADD;
            end
            5'd15: begin
               w.wb_op = WB_SIGNAL;
            end
            5'd16: begin
               w.emit   = 1'b1;
               w.jmp    = JMP_ALWAYS;
               w.target = PC_WAIT;
            end
            5'd17: begin
               w.wb_op  = WB_SEED;
               w.jmp    = JMP_ALWAYS;
               w.target = PC_EMIT;
            end
            default: begin
               w.jmp    = JMP_ALWAYS;
               w.target = PC_WAIT;
            end
         endcase
         return w;
      end
   endfunction

endpackage
`default_nettype wire

// ----- hdl/macd_seq.sv -----
// Microprogram sequencer: step counter, program ROM and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none
module macd_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_accept,
   input  wire logic                   seed,
   input  wire logic                   out_free,
   output macd_pkg::ctl_word_type      ctl
);

   macd_pkg::pc_type pc_ff;
   macd_pkg::pc_type pc_in;
   logic             hold;

   always_comb begin
      ctl = macd_pkg::ucode(pc_ff);
   end

   always_comb begin
      hold  = (ctl.wait_in && !req_accept) || (ctl.emit && !out_free);
      pc_in = pc_ff;
      if (!hold) begin
         case (ctl.jmp)
            macd_pkg::JMP_NEXT:   pc_in = pc_ff + 1'b1;
            macd_pkg::JMP_SEED:   pc_in = seed ? ctl.target : pc_ff + 1'b1;
            macd_pkg::JMP_ALWAYS: pc_in = ctl.target;
            default:              pc_in = macd_pkg::PC_WAIT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= macd_pkg::PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/macd_ema_stream.sv -----
// Top level: MACD stream with shared-multiplier datapath driven by the microsequencer.
`timescale 1ns / 1ps
`default_nettype none
// MACD over a price stream, one price per word, oldest first. A word with
// req_window_start high seeds both price averages with the price and clears the
// signal; others advance the short, long and signal exponential averages in
// Q.FRAC_BITS fixed point, flooring each step. Every word yields one result word
// of diff, signal and 2*(diff-signal). An accepted word runs through the
// microprogram to the result register (a window start skips the averages): the three
// average updates run one after another through a single 18x26 signed multiplier,
// two partial products each, stepped by the microprogram. The next word is taken in
// the cycle after the result is registered at the earliest, so no word is taken
// before the previous one is through. A new word is accepted while the previous
// result still waits in the output register. Alpha registers above one act as one.
module macd_ema_stream #(
   parameter int PRICE_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_write,
   input  wire logic [macd_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [macd_pkg::CSR_DATA_BITS-1:0]      csr_data,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic [PRICE_BITS-1:0]                   req_price,
   input  wire logic                                    req_window_start,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [PRICE_BITS+FRAC_BITS:0]         rsp_diff_value,
   output logic signed [PRICE_BITS+FRAC_BITS:0]         rsp_signal_value,
   output logic signed [PRICE_BITS+FRAC_BITS+2:0]       rsp_histogram_value
);

   localparam int AVGW  = PRICE_BITS + FRAC_BITS;
   localparam int DIFFW = AVGW + 1;
   localparam int HISTW = AVGW + 3;
   localparam int DW    = AVGW + 2;
   localparam int K     = (DW + 1) / 2;
   localparam int HW    = DW - K;
   localparam int MB    = K + 1;
   localparam int AW    = FRAC_BITS + 1;
   localparam int MA    = AW + 1;
   localparam int PW    = MA + MB;
   localparam int ACCW  = MA + DW;
   localparam int SW    = ACCW - FRAC_BITS;
   localparam int CW    = (AW > macd_pkg::CSR_DATA_BITS) ? AW : macd_pkg::CSR_DATA_BITS;

   macd_pkg::ctl_word_type ctl;

   logic [macd_pkg::CSR_DATA_BITS-1:0] alpha_short_ff, alpha_long_ff, alpha_signal_ff;
   logic [PRICE_BITS-1:0]              price_ff;
   logic                               seed_ff;
   logic [AVGW-1:0]                    short_ff, short_in;
   logic [AVGW-1:0]                    long_ff, long_in;
   logic signed [DIFFW-1:0]            diff_ff, diff_in;
   logic signed [DIFFW-1:0]            signal_ff, signal_in;
   logic signed [DW-1:0]               d_ff, d_in;
   logic signed [PW-1:0]               p_ff, p_in;
   logic signed [ACCW-1:0]             acc_ff, acc_in;
   logic                               rsp_valid_ff;
   logic signed [DIFFW-1:0]            rsp_diff_ff, rsp_signal_ff;
   logic signed [HISTW-1:0]            rsp_hist_ff, hist_in;

   logic                               req_accept;
   logic                               out_free;
   logic [AVGW-1:0]                    x;
   logic [macd_pkg::CSR_DATA_BITS-1:0] alpha_raw;
   logic [CW-1:0]                      alpha_ext;
   logic [CW-1:0]                      one_ext;
   logic [AW-1:0]                      alpha;
   logic signed [MA-1:0]               mul_a;
   logic signed [MB-1:0]               mul_b;
   logic signed [SW-1:0]               step;
   logic signed [SW-1:0]               base;
   logic signed [SW-1:0]               sum;
   logic signed [DIFFW:0]              hist_half;

   assign req_accept = req_valid && ctl.wait_in;
   assign req_stall  = !ctl.wait_in;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   macd_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .seed       (seed_ff),
      .out_free   (out_free),
      .ctl        (ctl)
   );

   assign x = {price_ff, {FRAC_BITS{1'b0}}};

   // weight select with clamp to one
   always_comb begin
      case (ctl.alpha_sel)
         macd_pkg::ALPHA_SHORT:  alpha_raw = alpha_short_ff;
         macd_pkg::ALPHA_LONG:   alpha_raw = alpha_long_ff;
         macd_pkg::ALPHA_SIGNAL: alpha_raw = alpha_signal_ff;
         default:                alpha_raw = alpha_short_ff;
      endcase
      alpha_ext = CW'(alpha_raw);
      one_ext   = CW'(1) << FRAC_BITS;
      alpha     = (alpha_ext > one_ext) ? AW'(one_ext) : AW'(alpha_ext);
      mul_a     = $signed({1'b0, alpha});
   end

   always_comb begin
      case (ctl.mul_op)
         macd_pkg::MUL_HI: mul_b = $signed({{(MB-HW){d_ff[DW-1]}}, d_ff[DW-1:K]});
         default:          mul_b = $signed({1'b0, d_ff[K-1:0]});
      endcase
      p_in = mul_a * mul_b;
   end

   always_comb begin
      case (ctl.d_src)
         macd_pkg::D_SHORT:  d_in = $signed({2'b00, x}) - $signed({2'b00, short_ff});
         macd_pkg::D_LONG:   d_in = $signed({2'b00, x}) - $signed({2'b00, long_ff});
         macd_pkg::D_SIGNAL: d_in = DW'(diff_ff) - DW'(signal_ff);
         default:            d_in = d_ff;
      endcase
   end

   always_comb begin
      case (ctl.acc_op)
         macd_pkg::ACC_LOAD: acc_in = ACCW'(p_ff);
         macd_pkg::ACC_ADD:  acc_in = acc_ff + (ACCW'(p_ff) <<< K);
         default:            acc_in = acc_ff;
      endcase
   end

   // write back: avg + floor(alpha * delta / one), or diff, or the seed; histogram
   always_comb begin
      step = $signed(acc_ff[ACCW-1:FRAC_BITS]);
      case (ctl.wb_op)
         macd_pkg::WB_SHORT:  base = $signed({{(SW-AVGW){1'b0}}, short_ff});
         macd_pkg::WB_LONG:   base = $signed({{(SW-AVGW){1'b0}}, long_ff});
         macd_pkg::WB_SIGNAL: base = SW'(signal_ff);
         default:             base = '0;
      endcase
      sum       = base + step;
      short_in  = short_ff;
      long_in   = long_ff;
      diff_in   = diff_ff;
      signal_in = signal_ff;
      case (ctl.wb_op)
         macd_pkg::WB_SHORT:  short_in  = sum[AVGW-1:0];
         macd_pkg::WB_LONG:   long_in   = sum[AVGW-1:0];
         macd_pkg::WB_DIFF:   diff_in   = $signed({1'b0, short_ff}) - $signed({1'b0, long_ff});
         macd_pkg::WB_SIGNAL: signal_in = sum[DIFFW-1:0];
         macd_pkg::WB_SEED: begin
            short_in  = x;
            long_in   = x;
            diff_in   = '0;
            signal_in = '0;
         end
         default: begin
            short_in = short_ff;
         end
      endcase
      hist_half = (DIFFW+1)'(diff_ff) - (DIFFW+1)'(signal_ff);
      hist_in   = {hist_half, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_short_ff  <= macd_pkg::CSR_DATA_BITS'(10082);
         alpha_long_ff   <= macd_pkg::CSR_DATA_BITS'(4855);
         alpha_signal_ff <= macd_pkg::CSR_DATA_BITS'(13107);
      end else if (csr_write) begin
         case (csr_index)
            macd_pkg::CSR_ALPHA_SHORT:  alpha_short_ff  <= csr_data;
            macd_pkg::CSR_ALPHA_LONG:   alpha_long_ff   <= csr_data;
            macd_pkg::CSR_ALPHA_SIGNAL: alpha_signal_ff <= csr_data;
            default: begin
               alpha_short_ff <= alpha_short_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff  <= '0;
         long_ff   <= '0;
         diff_ff   <= '0;
         signal_ff <= '0;
         seed_ff   <= 1'b0;
      end else begin
         short_ff  <= short_in;
         long_ff   <= long_in;
         diff_ff   <= diff_in;
         signal_ff <= signal_in;
         if (req_accept) begin
            seed_ff <= req_window_start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         price_ff <= req_price;
      end
      d_ff   <= d_in;
      p_ff   <= p_in;
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit && out_free) begin
         rsp_diff_ff   <= diff_ff;
         rsp_signal_ff <= signal_ff;
         rsp_hist_ff   <= hist_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_diff_value      = rsp_diff_ff;
   assign rsp_signal_value    = rsp_signal_ff;
   assign rsp_histogram_value = rsp_hist_ff;

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Testbench for macd_ema_stream: directed table plus random price windows, checked word by word.
`timescale 1ns / 1ps
module tb_top;

   localparam logic [1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic [16:0] WEIGHT_ONE = 17'd65536;

   typedef struct packed {
      logic [48:0] diff_value;
      logic [48:0] signal_value;
      logic [50:0] histogram_value;
   } macd_word_type;

   typedef enum logic {
      ROW_PRICE,
      ROW_ALPHA
   } row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      logic [1:0]    index;
      logic [16:0]   data;
      logic [31:0]   price;
      logic          window_start;
      logic          known;
      macd_word_type result;
   } stim_row_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [macd_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [macd_pkg::CSR_DATA_BITS-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_price = '0;
   logic req_window_start = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [48:0] rsp_diff_value;
   logic signed [48:0] rsp_signal_value;
   logic signed [50:0] rsp_histogram_value;

   // predictor state and weights
   logic signed [63:0] ema_short = '0;
   logic signed [63:0] ema_long = '0;
   logic signed [63:0] ema_signal = '0;
   logic [16:0] w_short = 17'd10082;
   logic [16:0] w_long = 17'd4855;
   logic [16:0] w_signal = 17'd13107;

   macd_word_type pending_macd[$];
   stim_row_type directed_rows[$];
   int unsigned fail_count = 0;
   logic [7:0] stall_tick = '0;
   stall_mode_type stall_mode = STALL_NONE;

   macd_ema_stream i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_price           (req_price),
      .req_window_start    (req_window_start),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_diff_value      (rsp_diff_value),
      .rsp_signal_value    (rsp_signal_value),
      .rsp_histogram_value (rsp_histogram_value)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // floor(alpha * (x - avg) / ONE) added to avg, weight clamped at one
   function automatic logic signed [63:0] ema_advance(input logic signed [63:0] avg,
                                                      input logic signed [63:0] x,
                                                      input logic [16:0] weight);
      logic signed [17:0] a;
      logic signed [81:0] prod;
      a = (weight > WEIGHT_ONE) ? 18'sd65536 : $signed({1'b0, weight});
      prod = a * (x - avg);
      return avg + (prod >>> 16);
   endfunction

   function automatic macd_word_type next_macd(input logic [31:0] price, input logic seed);
      logic signed [63:0] x;
      logic signed [63:0] diff;
      logic signed [63:0] hist;
      macd_word_type r;
      x = $signed({16'd0, price, 16'd0});
      if (seed) begin
         ema_short = x;
         ema_long = x;
         ema_signal = '0;
         diff = '0;
      end else begin
         ema_short = ema_advance(ema_short, x, w_short);
         ema_long = ema_advance(ema_long, x, w_long);
         diff = ema_short - ema_long;
         ema_signal = ema_advance(ema_signal, diff, w_signal);
      end
      hist = 2 * (diff - ema_signal);
      r.diff_value = diff[48:0];
      r.signal_value = ema_signal[48:0];
      r.histogram_value = hist[50:0];
      return r;
   endfunction

   function automatic stim_row_type price_row(input logic [31:0] price, input logic ws);
      stim_row_type r;
      r = '0;
      r.kind = ROW_PRICE;
      r.price = price;
      r.window_start = ws;
      return r;
   endfunction

   function automatic stim_row_type fixed_row(input logic [31:0] price, input logic ws,
                                              input logic [48:0] d, input logic [48:0] s,
                                              input logic [50:0] h);
      stim_row_type r;
      r = price_row(price, ws);
      r.known = 1'b1;
      r.result = '{diff_value: d, signal_value: s, histogram_value: h};
      return r;
   endfunction

   function automatic stim_row_type alpha_row(input logic [1:0] index, input logic [16:0] data);
      stim_row_type r;
      r = '0;
      r.kind = ROW_ALPHA;
      r.index = index;
      r.data = data;
      return r;
   endfunction

   function automatic logic [16:0] pick_alpha();
      case ($urandom_range(0, 5))
         0: return 17'd0;
         1: return WEIGHT_ONE;
         2: return 17'h1FFFF;
         3: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(1, 65535));
      endcase
   endfunction

   task automatic add_row(input stim_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endtask

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%s", msg);
   endtask

   task automatic wait_drained();
      while (pending_macd.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_alpha(input logic [1:0] index, input logic [16:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      case (index)
         macd_pkg::CSR_ALPHA_SHORT: w_short = value;
         macd_pkg::CSR_ALPHA_LONG: w_long = value;
         macd_pkg::CSR_ALPHA_SIGNAL: w_signal = value;
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_price(input logic [31:0] price, input logic ws, input logic hold,
                             input int unsigned gap, input logic known,
                             input macd_word_type known_result);
      macd_word_type predicted;
      req_valid <= 1'b1;
      req_price <= price;
      req_window_start <= ws;
      do @(posedge clock); while (req_stall);
      predicted = next_macd(price, ws);
      pending_macd.insert(pending_macd.size(), known ? known_result : predicted);
      if (!hold) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // result side: check accepted words, stall on a mode redrawn when the 8-bit tick wraps
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_macd.size() == 0) begin
            log_failure($sformatf("unexpected word: diff %h signal %h hist %h",
                                  rsp_diff_value, rsp_signal_value, rsp_histogram_value));
         end else begin
            if (rsp_diff_value !== pending_macd[0].diff_value ||
                rsp_signal_value !== pending_macd[0].signal_value ||
                rsp_histogram_value !== pending_macd[0].histogram_value)
               log_failure($sformatf(
                  "mismatch (exp/act): diff %h/%h signal %h/%h hist %h/%h",
                  pending_macd[0].diff_value, rsp_diff_value,
                  pending_macd[0].signal_value, rsp_signal_value,
                  pending_macd[0].histogram_value, rsp_histogram_value));
            void'(pending_macd.pop_front());
         end
      end
      stall_tick <= stall_tick + 8'd1;
      if (stall_tick == 8'd0)
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_tick[3];
      endcase
   end

   initial begin
      stim_row_type row;
      logic hold;
      logic ws;
      logic [31:0] price;
      logic [31:0] level;
      int unsigned burst_left;
      int unsigned gap;

      // no seed after reset, then seeds at the extremes
      add_row(fixed_row(32'd0, 1'b0, '0, '0, '0));
      add_row(price_row(32'hFFFF_FFFF, 1'b0));
      add_row(price_row(32'h1234_5678, 1'b0));
      add_row(fixed_row(32'hFFFF_FFFF, 1'b1, '0, '0, '0));
      add_row(price_row(32'd0, 1'b0));
      // short weight one, long weight zero, signal weight above one, stray index
      add_row(alpha_row(macd_pkg::CSR_ALPHA_SHORT, WEIGHT_ONE));
      add_row(alpha_row(macd_pkg::CSR_ALPHA_LONG, 17'd0));
      add_row(alpha_row(macd_pkg::CSR_ALPHA_SIGNAL, 17'h1FFFF));
      add_row(alpha_row(CSR_UNUSED_INDEX, 17'd0));
      add_row(fixed_row(32'd0, 1'b1, '0, '0, '0));
      add_row(fixed_row(32'hFFFF_FFFF, 1'b0, 49'h0_FFFF_FFFF_0000,
                        49'h0_FFFF_FFFF_0000, '0));
      add_row(fixed_row(32'd0, 1'b0, '0, '0, '0));
      add_row(price_row(32'hAAAA_AAAA, 1'b0));
      // short frozen, long follows, signal frozen
      add_row(alpha_row(macd_pkg::CSR_ALPHA_SHORT, 17'd0));
      add_row(alpha_row(macd_pkg::CSR_ALPHA_LONG, WEIGHT_ONE));
      add_row(alpha_row(macd_pkg::CSR_ALPHA_SIGNAL, 17'd0));
      add_row(fixed_row(32'hFFFF_FFFF, 1'b1, '0, '0, '0));
      add_row(fixed_row(32'd0, 1'b0, 49'h0_FFFF_FFFF_0000, '0,
                        51'h1_FFFF_FFFE_0000));
      add_row(fixed_row(32'd0, 1'b1, '0, '0, '0));
      add_row(fixed_row(32'hFFFF_FFFF, 1'b0, -49'sh0_FFFF_FFFF_0000, '0,
                        -51'sh1_FFFF_FFFE_0000));
      add_row(price_row(32'h5555_5555, 1'b0));
      add_row(alpha_row(macd_pkg::CSR_ALPHA_SHORT, 17'd10082));
      add_row(alpha_row(macd_pkg::CSR_ALPHA_LONG, 17'd4855));
      add_row(alpha_row(macd_pkg::CSR_ALPHA_SIGNAL, 17'd13107));
      add_row(price_row(32'h0001_0000, 1'b1));
      add_row(price_row(32'h0001_2345, 1'b0));
      add_row(price_row(32'h0000_FFFF, 1'b0));
      add_row(price_row(32'h8000_0000, 1'b0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_ALPHA) begin
            wait_drained();
            write_alpha(row.index, row.data);
         end else begin
            hold = (i + 1 < directed_rows.size()) && (directed_rows[i + 1].kind == ROW_PRICE)
                   && ($urandom_range(0, 1) == 1);
            send_price(row.price, row.window_start, hold, $urandom_range(1, 4),
                       row.known, row.result);
         end
      end

      // random windows, new weights between phases once the pipe is empty
      level = $urandom();
      burst_left = 0;
      gap = 1;
      for (int phase = 0; phase < 7; phase++) begin
         wait_drained();
         write_alpha(macd_pkg::CSR_ALPHA_SHORT, pick_alpha());
         write_alpha(macd_pkg::CSR_ALPHA_LONG, pick_alpha());
         write_alpha(macd_pkg::CSR_ALPHA_SIGNAL, pick_alpha());
         for (int n = 0; n < 100; n++) begin
            ws = ($urandom_range(0, 15) == 0);
            if (ws)
               level = $urandom() >> $urandom_range(0, 24);
            case ($urandom_range(0, 7))
               0: price = $urandom();
               1: price = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'd0;
               default: price = level + 32'($urandom_range(0, 4095)) - 32'd2048;
            endcase
            level = price;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap = $urandom_range(1, 12);
            end
            burst_left--;
            send_price(price, ws, (burst_left != 0) && (n != 99), gap, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_macd.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
